/* rtl/gn_pkg.sv */
// Shared constants and types for the gradient noise pipeline.
`default_nettype none
package gn_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 16;
  localparam int CELL_W      = 6;
  localparam int SIZE_W      = 13;
  localparam int GRAD_W      = 16;
  localparam int OUT_W       = 16;

  localparam int NUM_W       = COORD_BITS + CELL_W;
  localparam int QUO_W       = NUM_W + FRAC_BITS;
  localparam int DIV_STAGES  = QUO_W;

  localparam int DX_W        = FRAC_BITS + 1;
  localparam int PROD_W      = GRAD_W + DX_W;
  localparam int DOT_SH      = FRAC_BITS - 8;
  localparam int DOT_W       = PROD_W + 1 - DOT_SH;
  localparam int WGT_W       = FRAC_BITS + 2;
  localparam int LERP_W      = DOT_W + 1;
  localparam int MUL1_W      = LERP_W + WGT_W;
  localparam int MUL2_W      = LERP_W + 1 + WGT_W;

  localparam int IP_STAGES   = 8;
  localparam int LOAD_STG    = DIV_STAGES + 1;
  localparam int PIPE_STAGES = LOAD_STG + 2 + IP_STAGES;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(4096);
  localparam logic [CELL_W-1:0] CELLS_RST  = CELL_W'(16);

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_CELLS_X = 2'd2,
    CFG_CELLS_Y = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EVAL = 1'b1
  } action_e;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gx;
  } grad_t;

  typedef struct packed {
    grad_t g00;
    grad_t g10;
    grad_t g01;
    grad_t g11;
  } corners_t;

  typedef struct packed {
    action_e             act;
    logic [TBL_AW-1:0]   ti;
    grad_t               g;
  } load_t;

endpackage
`default_nettype wire

/* rtl/gn_ram.sv */
// Generic synchronous RAM with one write port and two registered read ports.
`default_nettype none
module gn_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/gn_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module gn_div (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [gn_pkg::NUM_W-1:0]       num_i,
  input  wire logic [gn_pkg::SIZE_W-1:0]      den_i,
  output logic      [gn_pkg::QUO_W-1:0]       quo_o
);
  import gn_pkg::*;

  logic [SIZE_W-1:0] rem_q  [DIV_STAGES];
  logic [QUO_W-1:0]  word_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
    logic [SIZE_W-1:0] rem_in;
    logic [QUO_W-1:0]  word_in;
    logic [SIZE_W:0]   trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign word_in = {num_i, {FRAC_BITS{1'b0}}};
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign word_in = word_q[s-1];
    end

    assign trial = {rem_in, word_in[QUO_W-1]};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? SIZE_W'(trial - {1'b0, den_i}) : trial[SIZE_W-1:0];
        word_q[s] <= {word_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = word_q[DIV_STAGES-1];

endmodule
`default_nettype wire

/* rtl/gn_interp.sv */
// Corner dot products, fade weights and bilinear blend with saturation.
`default_nettype none
module gn_interp (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire gn_pkg::corners_t              corners_i,
  input  wire logic [gn_pkg::FRAC_BITS-1:0]  fx_i,
  input  wire logic [gn_pkg::FRAC_BITS-1:0]  fy_i,
  output logic signed [gn_pkg::OUT_W-1:0]    noise_o
);
  import gn_pkg::*;

  localparam int SQ_W  = 2 * FRAC_BITS;
  localparam int SUM_W = PROD_W + 1;
  localparam int FIN_W = LERP_W + 1 + WGT_W - FRAC_BITS;
  localparam logic signed [FIN_W-9:0] SAT_HI = (FIN_W-8)'(32767);
  localparam logic signed [FIN_W-9:0] SAT_LO = -(FIN_W-8)'(32768);

  logic signed [DX_W-1:0] dx0, dx1, dy0, dy1;
  logic [SQ_W-1:0]        sqx, sqy, cbx, cby;

  logic signed [PROD_W-1:0] p_q [8];
  logic [FRAC_BITS-1:0]     fx1_q, fy1_q, t2x_q, t2y_q, t2x2_q, t2y2_q, t3x_q, t3y_q;
  logic signed [DOT_W-1:0]  dot_q [4];
  logic signed [WGT_W-1:0]  wx_q, wy3_q, wy4_q, wy5_q, wy6_q;
  logic signed [LERP_W-1:0] d1_q, d2_q;
  logic signed [DOT_W-1:0]  u3_q, s3_q, u4_q, s4_q;
  logic signed [MUL1_W-1:0] m1_q, m2_q;
  logic signed [LERP_W-1:0] a1_q, a2_q, a16_q, a17_q;
  logic signed [LERP_W:0]   d3_q;
  logic signed [MUL2_W-1:0] m3_q;
  logic signed [SUM_W-1:0]  sum [4];
  logic signed [FIN_W-1:0]  fin;
  logic signed [FIN_W-9:0]  fin_sh;
  logic signed [OUT_W-1:0]  sat;

  assign dx0 = $signed({1'b0, fx_i});
  assign dx1 = $signed({1'b1, fx_i});
  assign dy0 = $signed({1'b0, fy_i});
  assign dy1 = $signed({1'b1, fy_i});
  assign sqx = fx_i * fx_i;
  assign sqy = fy_i * fy_i;
  assign cbx = t2x_q * fx1_q;
  assign cby = t2y_q * fy1_q;

  for (genvar k = 0; k < 4; k++) begin : g_sum
    assign sum[k] = SUM_W'(p_q[2*k]) + SUM_W'(p_q[2*k+1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= corners_i.g00.gx * dx0;
      p_q[1] <= corners_i.g00.gy * dy0;
      p_q[2] <= corners_i.g10.gx * dx1;
      p_q[3] <= corners_i.g10.gy * dy0;
      p_q[4] <= corners_i.g01.gx * dx0;
      p_q[5] <= corners_i.g01.gy * dy1;
      p_q[6] <= corners_i.g11.gx * dx1;
      p_q[7] <= corners_i.g11.gy * dy1;
      t2x_q  <= sqx[SQ_W-1:FRAC_BITS];
      t2y_q  <= sqy[SQ_W-1:FRAC_BITS];
      fx1_q  <= fx_i;
      fy1_q  <= fy_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        dot_q[k] <= sum[k][SUM_W-1:DOT_SH];
      end
      t3x_q  <= cbx[SQ_W-1:FRAC_BITS];
      t3y_q  <= cby[SQ_W-1:FRAC_BITS];
      t2x2_q <= t2x_q;
      t2y2_q <= t2y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q  <= $signed(WGT_W'(3 * {2'b00, t2x2_q}) - WGT_W'({t3x_q, 1'b0}));
      wy3_q <= $signed(WGT_W'(3 * {2'b00, t2y2_q}) - WGT_W'({t3y_q, 1'b0}));
      d1_q  <= LERP_W'(dot_q[1]) - LERP_W'(dot_q[0]);
      d2_q  <= LERP_W'(dot_q[3]) - LERP_W'(dot_q[2]);
      u3_q  <= dot_q[0];
      s3_q  <= dot_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= d1_q * wx_q;
      m2_q  <= d2_q * wx_q;
      u4_q  <= u3_q;
      s4_q  <= s3_q;
      wy4_q <= wy3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= LERP_W'(MUL1_W'(u4_q) + (m1_q >>> FRAC_BITS));
      a2_q  <= LERP_W'(MUL1_W'(s4_q) + (m2_q >>> FRAC_BITS));
      wy5_q <= wy4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d3_q  <= (LERP_W+1)'(a2_q) - (LERP_W+1)'(a1_q);
      a16_q <= a1_q;
      wy6_q <= wy5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m3_q  <= d3_q * wy6_q;
      a17_q <= a16_q;
    end
  end

  assign fin    = FIN_W'(a17_q) + FIN_W'(m3_q >>> FRAC_BITS);
  assign fin_sh = fin[FIN_W-1:8];

  always_comb begin
    if (fin_sh > SAT_HI) begin
      sat = OUT_W'(SAT_HI);
    end else if (fin_sh < SAT_LO) begin
      sat = OUT_W'(SAT_LO);
    end else begin
      sat = fin_sh[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      noise_o <= sat;
    end
  end

endmodule
`default_nettype wire

/* rtl/gradient_noise_2d_top.sv */
// Top level of the 2D gradient noise pipeline.
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Loads write the gradient table from the last ld_q register, in item order; no result.
// Reset clears all valid flags and loads default size and cell counts.
// Gradient table contents are undefined until loaded.
`default_nettype none
module gradient_noise_2d_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          action_i,
  input  wire logic [11:0]                   table_index_i,
  input  wire logic signed [15:0]            gradient_x_i,
  input  wire logic signed [15:0]            gradient_y_i,
  input  wire logic [gn_pkg::COORD_BITS-1:0] pixel_x_i,
  input  wire logic [gn_pkg::COORD_BITS-1:0] pixel_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [15:0]                 noise_value_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire gn_pkg::cfg_idx_e              cfg_index_i,
  input  wire logic [gn_pkg::SIZE_W-1:0]     cfg_data_i
);
  import gn_pkg::*;

  logic [SIZE_W-1:0] width_q, height_q, w_eff, h_eff;
  logic [CELL_W-1:0] cells_x_q, cells_y_q;
  logic [CELL_W:0]   m;

  logic                    adv;
  logic                    vld_q [PIPE_STAGES];
  load_t                   ld_q  [LOAD_STG+1];
  logic [NUM_W-1:0]        sx_q, sy_q;
  logic [QUO_W-1:0]        qx, qy;
  logic [TBL_AW-1:0]       base_q;
  logic [FRAC_BITS-1:0]    fxb_q, fyb_q, fxr_q, fyr_q;
  logic                    we;
  corners_t                corners;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
      cells_x_q <= CELLS_RST;
      cells_y_q <= CELLS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:   width_q   <= cfg_data_i;
        CFG_HEIGHT:  height_q  <= cfg_data_i;
        CFG_CELLS_X: cells_x_q <= cfg_data_i[CELL_W-1:0];
        CFG_CELLS_Y: cells_y_q <= cfg_data_i[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (width_q == '0)  ? SIZE_W'(1) : width_q;
  assign h_eff = (height_q == '0) ? SIZE_W'(1) : height_q;
  assign m     = (CELL_W+1)'(cells_y_q) + (CELL_W+1)'(1);

  assign adv        = !vld_q[PIPE_STAGES-1] || out_ready_i;
  assign in_ready_o = adv;

  // drop loads from the valid chain once they have written the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (k == LOAD_STG + 1) begin
          vld_q[k] <= vld_q[k-1] && (ld_q[LOAD_STG].act == ACT_EVAL);
        end else begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q       <= pixel_x_i * cells_x_q;
      sy_q       <= pixel_y_i * cells_y_q;
      ld_q[0].act <= action_e'(action_i);
      ld_q[0].ti  <= table_index_i[TBL_AW-1:0];
      ld_q[0].g   <= '{gy: gradient_y_i, gx: gradient_x_i};
      for (int k = 1; k <= LOAD_STG; k++) begin
        ld_q[k] <= ld_q[k-1];
      end
    end
  end

  gn_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (sx_q),
    .den_i (w_eff),
    .quo_o (qx)
  );

  gn_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (sy_q),
    .den_i (h_eff),
    .quo_o (qy)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      base_q <= TBL_AW'(qx[FRAC_BITS +: TBL_AW] * TBL_AW'(m)) + qy[FRAC_BITS +: TBL_AW];
      fxb_q  <= qx[FRAC_BITS-1:0];
      fyb_q  <= qy[FRAC_BITS-1:0];
      fxr_q  <= fxb_q;
      fyr_q  <= fyb_q;
    end
  end

  assign we = adv && vld_q[LOAD_STG] && (ld_q[LOAD_STG].act == ACT_LOAD);

  gn_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH ($bits(grad_t))
  ) u_ram_row0 (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (ld_q[LOAD_STG].ti),
    .wdata_i   (ld_q[LOAD_STG].g),
    .re_i      (adv),
    .raddr_a_i (base_q),
    .raddr_b_i (base_q + TBL_AW'(m)),
    .rdata_a_o (corners.g00),
    .rdata_b_o (corners.g10)
  );

  gn_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH ($bits(grad_t))
  ) u_ram_row1 (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (ld_q[LOAD_STG].ti),
    .wdata_i   (ld_q[LOAD_STG].g),
    .re_i      (adv),
    .raddr_a_i (base_q + TBL_AW'(1)),
    .raddr_b_i (base_q + TBL_AW'(m) + TBL_AW'(1)),
    .rdata_a_o (corners.g01),
    .rdata_b_o (corners.g11)
  );

  gn_interp u_interp (
    .clk_i     (clk_i),
    .en_i      (adv),
    .corners_i (corners),
    .fx_i      (fxr_q),
    .fy_i      (fyr_q),
    .noise_o   (noise_value_o)
  );

  assign out_valid_o = vld_q[PIPE_STAGES-1];

endmodule
`default_nettype wire

/* rtl/gn_chk.sv */
// Port-level checker for the gradient noise top level, with its bind.
`default_nettype none
module gn_chk (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic signed [15:0]   noise_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(noise_value_o))
    else $error("result changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  a_rise_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result appeared without pipeline advance");

endmodule

bind gradient_noise_2d_top gn_chk u_gn_chk (.*);
`default_nettype wire
